// ----- rtl/core/m3i_pkg.sv -----
// ----------------------------------------------------------------------------
// m3i_pkg
// Types, widths and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int THR_W     = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int COF_W     = PROD_W + 1;
   localparam int COF_MAG_W = PROD_W;
   localparam int PART_W    = COF_W;
   localparam int DET_W     = DATA_W + COF_W;
   localparam int MAG_W     = DET_W - 1;
   localparam int DIV_STEPS = DATA_W + 1;
   localparam int QUO_W     = DIV_STEPS;
   localparam int THR_SHIFT = 3 * FRAC_W;
   localparam int N_LANES   = 9;
   localparam int PIPE_DEPTH = 5 + DIV_STEPS + 2;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   // Operand indexes (row * 3 + column) of each adjugate entry: a*b - c*d.
   localparam int COF_IDX [N_LANES][4] = '{
      '{8, 4, 5, 7}, '{2, 7, 8, 1}, '{5, 1, 2, 4},
      '{5, 6, 8, 3}, '{8, 0, 2, 6}, '{2, 3, 5, 0},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r00;
      logic signed [DATA_W-1:0] r01;
      logic signed [DATA_W-1:0] r02;
      logic signed [DATA_W-1:0] r10;
      logic signed [DATA_W-1:0] r11;
      logic signed [DATA_W-1:0] r12;
      logic signed [DATA_W-1:0] r20;
      logic signed [DATA_W-1:0] r21;
      logic signed [DATA_W-1:0] r22;
      logic                     singular;
      logic                     overflowed;
   } rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic             big;
   } lane_in_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r;
      logic                     ovf;
   } lane_out_type;

endpackage

// ----- rtl/core/m3i_cofactor.sv -----
// ----------------------------------------------------------------------------
// m3i_cofactor
// One cofactor lane: two registered products, then their registered difference.
// ----------------------------------------------------------------------------
module m3i_cofactor (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [m3i_pkg::DATA_W-1:0]  a,
   input  logic signed [m3i_pkg::DATA_W-1:0]  b,
   input  logic signed [m3i_pkg::DATA_W-1:0]  c,
   input  logic signed [m3i_pkg::DATA_W-1:0]  d,
   output logic signed [m3i_pkg::COF_W-1:0]   cof
);
   import m3i_pkg::*;

   logic signed [PROD_W-1:0] ab_ff, ab_in, cd_ff, cd_in;
   logic signed [COF_W-1:0]  cof_ff, cof_in;

   assign ab_in  = a * b;
   assign cd_in  = c * d;
   assign cof_in = COF_W'(ab_ff) - COF_W'(cd_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ab_ff  <= ab_in;
         cd_ff  <= cd_in;
         cof_ff <= cof_in;
      end
   end

   assign cof = cof_ff;

endmodule

// ----- rtl/core/m3i_det.sv -----
// ----------------------------------------------------------------------------
// m3i_det
// Determinant from row 0 and its cofactors: split partial products, then sum.
// ----------------------------------------------------------------------------
module m3i_det (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [m3i_pkg::DATA_W-1:0]  m0,
   input  logic signed [m3i_pkg::DATA_W-1:0]  m1,
   input  logic signed [m3i_pkg::DATA_W-1:0]  m2,
   input  logic signed [m3i_pkg::COF_W-1:0]   c0,
   input  logic signed [m3i_pkg::COF_W-1:0]   c3,
   input  logic signed [m3i_pkg::COF_W-1:0]   c6,
   output logic signed [m3i_pkg::DET_W-1:0]   det
);
   import m3i_pkg::*;

   logic signed [DATA_W-1:0] mv [3];
   logic signed [COF_W-1:0]  cv [3];
   logic signed [PART_W-1:0] lo_in [3];
   logic signed [PART_W-1:0] hi_in [3];
   logic signed [PART_W-1:0] lo_ff [3];
   logic signed [PART_W-1:0] hi_ff [3];
   logic signed [DET_W-1:0]  det_ff, det_in;

   assign mv[0] = m0;
   assign mv[1] = m1;
   assign mv[2] = m2;
   assign cv[0] = c0;
   assign cv[1] = c3;
   assign cv[2] = c6;

   for (genvar i = 0; i < 3; i++) begin : g_part
      assign lo_in[i] = mv[i] * $signed({1'b0, cv[i][DATA_W-1:0]});
      assign hi_in[i] = mv[i] * $signed(cv[i][COF_W-1:DATA_W]);
   end

   always_comb begin
      det_in = '0;
      for (int i = 0; i < 3; i++) begin
         det_in = det_in + (DET_W'(hi_ff[i]) <<< DATA_W) + DET_W'(lo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
         det_ff <= det_in;
      end
   end

   assign det = det_ff;

endmodule

// ----- rtl/core/m3i_div_lane.sv -----
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider, one quotient bit per stage, then rounding
// and saturation of one inverse entry.
// ----------------------------------------------------------------------------
module m3i_div_lane (
   input  logic                                                  clock,
   input  logic                                                  en,
   input  logic [m3i_pkg::DIV_STEPS-1:0][m3i_pkg::MAG_W-1:0]     den,
   input  m3i_pkg::lane_in_type                                  lin,
   output m3i_pkg::lane_out_type                                 lout
);
   import m3i_pkg::*;

   localparam logic [DATA_W:0] LIM_NEG = (DATA_W + 1)'(1) << (DATA_W - 1);
   localparam logic [DATA_W:0] LIM_POS = LIM_NEG - (DATA_W + 1)'(1);
   localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W - 1){1'b0}}};

   logic [MAG_W-1:0]     rem_ff [DIV_STEPS];
   logic [MAG_W-1:0]     rem_in [DIV_STEPS];
   logic [QUO_W-1:0]     q_ff   [DIV_STEPS];
   logic [QUO_W-1:0]     q_in   [DIV_STEPS];
   logic [DIV_STEPS-1:0] neg_ff, big_ff;

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [MAG_W-1:0] prev;
      logic [QUO_W-1:0] prevq;
      logic [MAG_W:0]   dbl;
      logic [MAG_W:0]   dext;
      logic             ge;
      if (j == 0) begin : g_first
         assign prev  = lin.mag;
         assign prevq = '0;
      end else begin : g_next
         assign prev  = rem_ff[j-1];
         assign prevq = q_ff[j-1];
      end
      assign dbl       = {prev, 1'b0};
      assign dext      = {1'b0, den[j]};
      assign ge        = dbl >= dext;
      assign rem_in[j] = ge ? MAG_W'(dbl - dext) : dbl[MAG_W-1:0];
      assign q_in[j]   = {prevq[QUO_W-2:0], ge};
   end

   logic [DATA_W:0]   mag, neg_mag;
   logic              neg, sat;
   lane_out_type      out_ff, out_in;
   logic [QUO_W-1:0]  qf;

   always_comb begin
      qf      = q_ff[DIV_STEPS-1];
      mag     = {1'b0, qf[QUO_W-1:1]} + (DATA_W + 1)'(qf[0]);
      neg_mag = (DATA_W + 1)'(0) - mag;
      neg     = neg_ff[DIV_STEPS-1] && (mag != '0);
      sat     = big_ff[DIV_STEPS-1] || (neg ? (mag > LIM_NEG) : (mag > LIM_POS));
      out_in.ovf = sat;
      if (sat) begin
         out_in.r = neg ? MIN_VAL : MAX_VAL;
      end else begin
         out_in.r = neg ? neg_mag[DATA_W-1:0] : mag[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
         end
         neg_ff <= {neg_ff[DIV_STEPS-2:0], lin.neg};
         big_ff <= {big_ff[DIV_STEPS-2:0], lin.big};
         out_ff <= out_in;
      end
   end

   assign lout = out_ff;

endmodule

// ----- rtl/core/matrix3x3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed Q16.16 3x3 matrix as adjugate over determinant.
// ----------------------------------------------------------------------------
// The req channel takes one matrix per item in req_data; the rsp channel
// returns one item per matrix with the nine inverse entries, rounded to the
// nearest step with ties away from zero and saturated, plus the singular and
// overflowed flags. The csr port writes the singular threshold, which should
// only change while no item is in flight.
// From acceptance until rsp_valid rises an item passes the cofactor product and
// difference registers, the determinant partial-product and sum registers, the
// magnitude and compare registers, 33 divider steps of one quotient bit each,
// the rounding register and the output register. While req_ready is high the
// pipeline accepts one item every cycle. When the receiver stalls, one further
// item lands in a skid register and the pipeline freezes with req_ready low
// until the skid entry moves into the output register. Synchronous reset
// empties the pipeline and both output registers and sets the threshold to one.
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  m3i_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output m3i_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [m3i_pkg::THR_W-1:0]     csr_wr_data
);
   import m3i_pkg::*;

   logic                     en;
   logic                     sk_v_ff;
   logic [THR_W-1:0]         thr_ff;
   logic [PIPE_DEPTH-1:0]    vld_ff;
   logic signed [DATA_W-1:0] mv [N_LANES];
   logic signed [COF_W-1:0]  cof [N_LANES];
   logic signed [DATA_W-1:0] row_ff1 [3];
   logic signed [DATA_W-1:0] row_ff2 [3];
   logic signed [COF_W-1:0]  cof_ff3 [N_LANES];
   logic signed [COF_W-1:0]  cof_ff4 [N_LANES];
   logic signed [DET_W-1:0]  det;
   logic [MAG_W-1:0]         adet_ff5, adet_in;
   logic                     dneg_ff5;
   logic [COF_MAG_W-1:0]     cmag_ff5 [N_LANES];
   logic [COF_MAG_W-1:0]     cmag_in  [N_LANES];
   logic [N_LANES-1:0]       cneg_ff5;
   lane_in_type              lin_ff [N_LANES];
   lane_out_type             lout [N_LANES];
   logic [DIV_STEPS-1:0][MAG_W-1:0] den_ff;
   logic [DIV_STEPS+1:0]     sing_ff;
   logic [MAG_W-1:0]         lim;

   assign en        = !sk_v_ff;
   assign req_ready = en;

   assign mv[0] = req_data.m00;
   assign mv[1] = req_data.m01;
   assign mv[2] = req_data.m02;
   assign mv[3] = req_data.m10;
   assign mv[4] = req_data.m11;
   assign mv[5] = req_data.m12;
   assign mv[6] = req_data.m20;
   assign mv[7] = req_data.m21;
   assign mv[8] = req_data.m22;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   for (genvar k = 0; k < N_LANES; k++) begin : g_cof
      m3i_cofactor u_cof (
         .clock (clock),
         .en    (en),
         .a     (mv[COF_IDX[k][0]]),
         .b     (mv[COF_IDX[k][1]]),
         .c     (mv[COF_IDX[k][2]]),
         .d     (mv[COF_IDX[k][3]]),
         .cof   (cof[k])
      );
   end

   m3i_det u_det (
      .clock (clock),
      .en    (en),
      .m0    (row_ff2[0]),
      .m1    (row_ff2[1]),
      .m2    (row_ff2[2]),
      .c0    (cof[0]),
      .c3    (cof[3]),
      .c6    (cof[6]),
      .det   (det)
   );

   always_comb begin
      adet_in = det[DET_W-1] ? MAG_W'(-det) : det[MAG_W-1:0];
      for (int k = 0; k < N_LANES; k++) begin
         cmag_in[k] = cof_ff4[k][COF_W-1] ? COF_MAG_W'(-cof_ff4[k])
                                          : cof_ff4[k][COF_MAG_W-1:0];
      end
      lim = MAG_W'(thr_ff) << THR_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            row_ff1[i] <= mv[i];
            row_ff2[i] <= row_ff1[i];
         end
         for (int k = 0; k < N_LANES; k++) begin
            cof_ff3[k]  <= cof[k];
            cof_ff4[k]  <= cof_ff3[k];
            cmag_ff5[k] <= cmag_in[k];
            cneg_ff5[k] <= cof_ff4[k][COF_W-1];
            lin_ff[k].mag <= MAG_W'(cmag_ff5[k]);
            lin_ff[k].neg <= cneg_ff5[k] ^ dneg_ff5;
            lin_ff[k].big <= MAG_W'(cmag_ff5[k]) >= adet_ff5;
         end
         adet_ff5 <= adet_in;
         dneg_ff5 <= det[DET_W-1];
         den_ff   <= {den_ff[DIV_STEPS-2:0], adet_ff5};
         sing_ff  <= {sing_ff[DIV_STEPS:0], adet_ff5 <= lim};
      end
   end

   for (genvar k = 0; k < N_LANES; k++) begin : g_div
      m3i_div_lane u_div (
         .clock (clock),
         .en    (en),
         .den   (den_ff),
         .lin   (lin_ff[k]),
         .lout  (lout[k])
      );
   end

   // Merge the lanes into one result item.
   rsp_type fin_d;
   logic    fin_v, sing;
   logic [N_LANES-1:0] ovf_vec;
   logic signed [DATA_W-1:0] rv [N_LANES];

   always_comb begin
      sing = sing_ff[DIV_STEPS+1];
      for (int k = 0; k < N_LANES; k++) begin
         rv[k]      = sing ? '0 : lout[k].r;
         ovf_vec[k] = lout[k].ovf;
      end
      fin_v            = vld_ff[PIPE_DEPTH-1];
      fin_d.r00        = rv[0];
      fin_d.r01        = rv[1];
      fin_d.r02        = rv[2];
      fin_d.r10        = rv[3];
      fin_d.r11        = rv[4];
      fin_d.r12        = rv[5];
      fin_d.r20        = rv[6];
      fin_d.r21        = rv[7];
      fin_d.r22        = rv[8];
      fin_d.singular   = sing;
      fin_d.overflowed = !sing && (|ovf_vec);
   end

   // Output register with one skid entry.
   logic    out_v_ff, out_v_in, sk_v_in, pop;
   rsp_type out_ff, out_in, sk_ff, sk_in;

   always_comb begin
      pop      = out_v_ff && rsp_ready;
      out_v_in = out_v_ff;
      out_in   = out_ff;
      sk_v_in  = sk_v_ff;
      sk_in    = sk_ff;
      if (sk_v_ff) begin
         if (pop) begin
            out_in  = sk_ff;
            sk_v_in = 1'b0;
         end
      end else if (fin_v) begin
         if (!out_v_ff || pop) begin
            out_in   = fin_d;
            out_v_in = 1'b1;
         end else begin
            sk_in   = fin_d;
            sk_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sk_ff  <= sk_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid entry held while output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid entry filled without an output stall");

   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |-> !rsp_data.overflowed)
      else $error("singular item reports overflow");
`endif

endmodule
